[rtl/spig_pkg.sv]
//------------------------------------------------------------------------------
// spig_pkg
// shared types and constants for the subtriangle point index generator
//------------------------------------------------------------------------------
package spig_pkg;

    localparam int ORDER_MAX_DEF = 16;
    localparam int ORD_W = 5;
    localparam int IDX_W = 8;
    localparam int PADDR_W = 3;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_ORDER = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_SEVEN = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LAT,
        ST_PNT,
        ST_EMIT,
        ST_WAIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic lat_step;
        logic pnt_start;
        logic pnt_step;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic lat_done;
        logic pnt_done;
        logic direct;
        logic last;
    } t_sts;

endpackage

[rtl/spig_ctrl.sv]
//------------------------------------------------------------------------------
// spig_ctrl
// sequencing state machine for one subtriangle item
//------------------------------------------------------------------------------
module spig_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_out_free,
    input  spig_pkg::t_sts  i_sts,
    output logic            o_busy,
    output spig_pkg::t_cmd  o_cmd
);
    import spig_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_in_fire) n_state = ST_SETUP;
            ST_SETUP: n_state = i_sts.direct ? ST_PNT : ST_LAT;
            ST_LAT:   if (i_sts.lat_done) n_state = ST_PNT;
            ST_PNT:   if (i_sts.pnt_done) n_state = ST_EMIT;
            ST_EMIT:  if (i_out_free) n_state = i_sts.last ? ST_IDLE : ST_WAIT;
            ST_WAIT:  n_state = ST_PNT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:  o_cmd.load = i_in_fire;
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_LAT:   o_cmd.lat_step = 1'b1;
            ST_PNT:   o_cmd.pnt_step = 1'b1;
            ST_EMIT:  o_cmd.emit = i_out_free;
            ST_WAIT:  o_cmd.pnt_start = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    // a load only happens from idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == ST_IDLE) else $error("load while busy");
    a_setup_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SETUP) else $error("no setup after load");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_out_free) else $error("emit into full output");

endmodule

[rtl/spig_dp.sv]
//------------------------------------------------------------------------------
// spig_dp
// lattice and point index datapath, one shell step per cycle
//------------------------------------------------------------------------------
module spig_dp #(
    parameter int ORDER_MAX = spig_pkg::ORDER_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  spig_pkg::t_cmd              i_cmd,
    input  logic [spig_pkg::IDX_W-1:0]  i_sub_index,
    input  logic [spig_pkg::ORD_W-1:0]  i_order,
    input  logic                        i_seven,
    output spig_pkg::t_sts              o_sts,
    output logic [1:0]                  o_slot,
    output logic [7:0]                  o_pidx,
    output logic [4:0]                  o_ba,
    output logic [4:0]                  o_bb,
    output logic [4:0]                  o_bc,
    output logic                        o_last,
    output logic                        o_oor
);
    import spig_pkg::*;

    localparam int W = 12;
    typedef logic signed [W-1:0] t_v;

    // captured item and configuration
    logic [IDX_W-1:0] r_s;
    t_v   r_ord;
    logic r_seven, r_oor;
    // lattice walk
    t_v   r_li, r_lo_ord, r_lhi, r_llo;
    logic r_inv;
    // corner triples
    t_v   r_c [3][3];
    logic [1:0] r_k;
    // point walk
    t_v   r_pn, r_phi, r_plo, r_pord, r_pmin;

    t_v   ord_eff, up, cnt, s_v;
    logic inv_now, oor_now, direct;
    t_v   c_init [3][3];

    always_comb begin
        if (i_order == '0) ord_eff = t_v'(1);
        else if (int'(i_order) > ORDER_MAX) ord_eff = t_v'(ORDER_MAX);
        else ord_eff = t_v'(i_order);
    end
    assign up = t_v'((r_ord * (r_ord + t_v'(1))) >>> 1);

    // item classification from the captured item
    assign s_v = t_v'(r_s);
    assign cnt = r_seven ? t_v'(6) : t_v'(r_ord * r_ord);
    assign inv_now = s_v >= up;
    assign oor_now = s_v >= cnt;
    // fixed corner cases bypass the lattice walk
    assign direct = r_seven || oor_now || (r_ord == t_v'(1))
                    || (r_ord == t_v'(2) && inv_now);

    // corner triples loaded at setup
    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) c_init[i][j] = '0;
        if (r_ord == t_v'(1)) begin
            c_init[0][2] = t_v'(1); c_init[1][0] = t_v'(1); c_init[2][1] = t_v'(1);
        end else if (r_ord == t_v'(2) && inv_now) begin
            c_init[0][0] = t_v'(1); c_init[0][1] = t_v'(1); c_init[1][1] = t_v'(1);
            c_init[1][2] = t_v'(1); c_init[2][0] = t_v'(1); c_init[2][2] = t_v'(1);
        end
    end

    // lattice walk step condition
    logic lat_go;
    assign lat_go = (r_li != 0) && (r_lo_ord > 0) && (r_li >= t_v'(3) * r_lo_ord);

    // final lattice triple from walked state
    t_v run, idx3, off, b0, b1, b2;
    logic [1:0] side;
    always_comb begin
        run = (r_lo_ord - t_v'(1) < t_v'(1)) ? t_v'(1) : r_lo_ord - t_v'(1);
        idx3 = r_li - t_v'(3);
        // side by compare, at most two subtractions
        if (idx3 >= t_v'(2) * run) side = 2'd2;
        else if (idx3 >= run) side = 2'd1;
        else side = 2'd0;
        off = idx3 - t_v'(side) * run;
        b0 = r_llo; b1 = r_llo; b2 = r_llo;
        if (r_li < 3) begin
            case (r_li[1:0])
                2'd0: b2 = r_lhi;
                2'd1: b0 = r_lhi;
                default: b1 = r_lhi;
            endcase
        end else begin
            case (side)
                2'd0: begin
                    b0 = r_llo + t_v'(1) + off; b2 = r_lhi - t_v'(1) - off;
                end
                2'd1: begin
                    b1 = r_llo + t_v'(1) + off; b0 = r_lhi - t_v'(1) - off;
                end
                default: begin
                    b2 = r_llo + t_v'(1) + off; b1 = r_lhi - t_v'(1) - off;
                end
            endcase
        end
    end

    // point walk
    t_v ca, cb, cc, pidx, span;
    logic pnt_go;
    always_comb begin
        ca = r_c[r_k][0]; cb = r_c[r_k][1]; cc = r_c[r_k][2];
        pnt_go = (r_pmin > r_plo) && (r_pord > 0);
        span = r_phi - r_plo - t_v'(1);
        if (cc == r_phi) pidx = r_pn;
        else if (ca == r_phi) pidx = r_pn + t_v'(1);
        else if (cb == r_phi) pidx = r_pn + t_v'(2);
        else if (cb == r_plo) pidx = r_pn + t_v'(3) + ca - (r_plo + t_v'(1));
        else if (cc == r_plo) pidx = r_pn + t_v'(3) + span + cb - (r_plo + t_v'(1));
        else pidx = r_pn + t_v'(3) + span + span + cc - (r_plo + t_v'(1));
    end

    // status to the controller
    always_comb begin
        o_sts = '0;
        o_sts.lat_done = !lat_go;
        o_sts.pnt_done = !pnt_go;
        o_sts.direct = direct;
        o_sts.last = r_oor || (r_k == 2'd2);
    end

    t_v m01;
    assign m01 = (r_c[r_k][0] < r_c[r_k][1]) ? r_c[r_k][0] : r_c[r_k][1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s <= i_sub_index;
            r_ord <= ord_eff;
            r_seven <= i_seven;
        end
        if (i_cmd.setup) begin
            r_oor <= oor_now;
            r_inv <= inv_now;
            r_li <= inv_now ? s_v - up : s_v;
            r_lo_ord <= inv_now ? r_ord - t_v'(2) : r_ord - t_v'(1);
            r_lhi <= inv_now ? r_ord - t_v'(2) : r_ord - t_v'(1);
            r_llo <= '0;
            r_k <= '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) r_c[i][j] <= c_init[i][j];
        end
        if (i_cmd.lat_step) begin
            if (lat_go) begin
                r_li <= r_li - t_v'(3) * r_lo_ord;
                r_lhi <= r_lhi - t_v'(2);
                r_llo <= r_llo + t_v'(1);
                r_lo_ord <= r_lo_ord - t_v'(3);
            end else if (!r_inv) begin
                r_c[0][0] <= b0; r_c[0][1] <= b1; r_c[0][2] <= b2 + t_v'(1);
                r_c[1][0] <= b0 + t_v'(1); r_c[1][1] <= b1; r_c[1][2] <= b2;
                r_c[2][0] <= b0; r_c[2][1] <= b1 + t_v'(1); r_c[2][2] <= b2;
            end else begin
                r_c[1][0] <= b0; r_c[1][1] <= b1 + t_v'(1); r_c[1][2] <= b2 + t_v'(1);
                r_c[2][0] <= b0 + t_v'(1); r_c[2][1] <= b1; r_c[2][2] <= b2 + t_v'(1);
                r_c[0][0] <= b0 + t_v'(1); r_c[0][1] <= b1 + t_v'(1); r_c[0][2] <= b2;
            end
        end
        if (i_cmd.setup || i_cmd.pnt_start || (i_cmd.lat_step && !lat_go)) begin
            r_pn <= '0; r_phi <= r_ord; r_plo <= '0; r_pord <= r_ord;
            r_pmin <= t_v'(127);
        end
        if (i_cmd.pnt_step) begin
            if (r_pmin == t_v'(127)) begin
                r_pmin <= (m01 < r_c[r_k][2]) ? m01 : r_c[r_k][2];
            end else if (pnt_go) begin
                r_pn <= r_pn + t_v'(3) * r_pord;
                r_phi <= r_phi - t_v'(2);
                r_plo <= r_plo + t_v'(1);
                r_pord <= r_pord - t_v'(3);
            end
        end
        if (i_cmd.emit) begin
            o_slot <= r_k;
            o_last <= r_oor || r_k == 2'd2;
            o_oor <= r_oor;
            if (r_oor) begin
                o_pidx <= '0; o_ba <= '0; o_bb <= '0; o_bc <= '0;
            end else if (r_seven) begin
                o_ba <= '0; o_bb <= '0; o_bc <= '0;
                case (r_k)
                    2'd0: o_pidx <= r_s;
                    2'd1: o_pidx <= (r_s < 3) ? r_s + 8'd3
                                   : ((r_s == 8'd5) ? 8'd0 : r_s - 8'd2);
                    default: o_pidx <= 8'd6;
                endcase
            end else begin
                o_pidx <= pidx[7:0];
                o_ba <= ca[4:0]; o_bb <= cb[4:0]; o_bc <= cc[4:0];
            end
            r_k <= r_k + 2'd1;
        end
    end

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_k != 2'd3) else $error("corner overrun");
    a_oor_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_oor) |-> r_k == 2'd0) else $error("oor not first");
    a_walk_ord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lat_step |-> r_llo <= t_v'(ORDER_MAX)) else $error("walk overrun");

endmodule

[rtl/subtriangle_point_index_gen.sv]
//------------------------------------------------------------------------------
// subtriangle_point_index_gen
// corner point indices of one subtriangle of a higher-order triangle
//------------------------------------------------------------------------------
// One item at a time: an accepted sub_index gives three corner transfers (or
// one flagged transfer when out of range), and s_axis_tready stays low until
// the last of them is loaded into the output register. After the accepting
// cycle the controller passes through a setup state, then walks the lattice of
// the upright or inverted cell one shell per cycle (out-of-range items, order
// one, the inverted order-two cell and seven-point mode skip this walk), then
// for each corner walks the point shells and loads the output register, with a
// wait state between corners. The output register is loaded only while it is
// empty or being taken by the receiver, so a held output stalls the item.
module subtriangle_point_index_gen #(
    parameter int ORDER_MAX = spig_pkg::ORDER_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [spig_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // sub_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // corner_slot[1:0], point_index[9:2], bary_a[14:10], bary_b[19:15],
    // bary_c[24:20], zero pad
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_corner
    output logic        m_axis_tuser    // out_of_range
);
    import spig_pkg::*;

    logic [ORD_W-1:0] r_order;
    logic r_seven, r_ovalid, busy, in_fire, out_free;
    t_cmd cmd;
    t_sts sts;
    logic [1:0] slot;
    logic [7:0] pidx;
    logic [4:0] ba, bb, bc;
    logic last, oor;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORD_W'(1);
            r_seven <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr == ADDR_ORDER) r_order <= pwdata[ORD_W-1:0];
            if (paddr == ADDR_SEVEN) r_seven <= pwdata[0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == ADDR_ORDER) prdata = 32'(r_order);
        else if (paddr == ADDR_SEVEN) prdata = 32'(r_seven);
    end

    assign s_axis_tready = i_rst_n && !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    spig_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(in_fire),
        .i_out_free(out_free), .i_sts(sts), .o_busy(busy), .o_cmd(cmd)
    );

    spig_dp #(.ORDER_MAX(ORDER_MAX)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_sub_index(s_axis_tdata),
        .i_order(r_order), .i_seven(r_seven), .o_sts(sts),
        .o_slot(slot), .o_pidx(pidx), .o_ba(ba), .o_bb(bb), .o_bc(bc),
        .o_last(last), .o_oor(oor)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.emit) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {7'd0, bc, bb, ba, pidx, slot};
    assign m_axis_tlast = last;
    assign m_axis_tuser = oor;

endmodule
